// ===== rtl/core/trie_shortest_root_replace_defines.svh =====
// ----------------------------------------------------------------------------
// Trie shortest root replace: assertion macros
// Concurrent assertion wrappers shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef TRIE_SHORTEST_ROOT_REPLACE_DEFINES_SVH
`define TRIE_SHORTEST_ROOT_REPLACE_DEFINES_SVH

// check a property on every clock edge outside reset
`define TSRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define TSRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/tsrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Trie shortest root replace package
// Shared constants, types and helpers of the trie rewriting block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsrr_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned ALPHABET      = 26;
  localparam int unsigned SLOT_W        = $clog2(ALPHABET);

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    MODE_WALK    = 2'd0,
    MODE_MATCHED = 2'd1,
    MODE_FAILED  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_A) && (c < (CH_A + 8'(ALPHABET)));
  endfunction

  function automatic logic [SLOT_W-1:0] letter_slot(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CH_A;
    return diff[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsrr_row_mem.sv =====
// ----------------------------------------------------------------------------
// Trie row memory
// Single-port-write, single-port-read synchronous memory, one trie node per
// row, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsrr_row_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 286,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trie_shortest_root_replace.sv =====
// ----------------------------------------------------------------------------
// Trie shortest root replace
// Builds a trie from dictionary bytes and rewrites sentence words to their
// shortest dictionary root.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one byte per transaction:
//   cmd_i = 0 inserts a dictionary byte, cmd_i = 1 rewrites a sentence byte.
//   A dictionary byte gives no result; a sentence byte gives one result on
//   the output channel (out_valid_o/out_ready_i).
//   Each byte passes two steps: the trie row read, then the update of the
//   row or walk state. The row memory read that names the next node keeps
//   a new byte out until the last one is through; a result is registered
//   when its byte's update step completes. The output register lets the next
//   byte in while a result waits; a sentence byte stalls in its update step
//   only while the previous result is still not taken.
//   After reset the block clears the row memory, one node row per cycle, over
//   all MAX_NODES rows (1024 by default); in_ready_o stays low meanwhile.
//   dict_error_o is sticky until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "trie_shortest_root_replace_defines.svh"

module trie_shortest_root_replace
  import tsrr_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       cmd_i,
  input  wire logic [7:0] letter_i,
  input  wire logic       word_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] out_char_o,
  output logic            has_char_o,
  output logic            sentence_end_o,
  output logic            dict_error_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned EW = NW + 1;
  localparam int unsigned RW = ALPHABET * EW;

  state_e           state_q, state_d;
  logic [NW-1:0]    clr_q, clr_d;
  logic [NW:0]      nodes_used_q, nodes_used_d;
  logic [NW-1:0]    walk_node_q, walk_node_d;
  mode_e            mode_q, mode_d;
  logic [NW-1:0]    ins_node_q, ins_node_d;
  logic             skip_q, skip_d;
  logic             error_q, error_d;
  logic             out_valid_q, out_valid_d;

  logic             cmd_q;
  logic [7:0]       letter_q;
  logic             word_end_q;

  logic [7:0]       out_char_q;
  logic             has_char_q;
  logic             sentence_end_q;
  logic             dict_error_q;

  logic             accept;
  logic             out_free;
  logic             walk_fire;
  logic             exec_done;
  logic             has;

  logic [RW-1:0]    rd_row;
  logic [RW-1:0]    wr_row;
  logic [EW-1:0]    rd_ent [ALPHABET];
  logic [EW-1:0]    cur_ent;
  logic [EW-1:0]    new_ent;
  logic             lower;
  logic [SLOT_W-1:0] slot;
  logic             dict_we;

  logic             mem_we;
  logic [NW-1:0]    mem_waddr;
  logic [RW-1:0]    mem_wdata;
  logic [NW-1:0]    mem_raddr;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign walk_fire = (state_q == ST_EXEC) && cmd_q && out_free;
  assign exec_done = cmd_q ? out_free : 1'b1;
  assign lower     = is_lower(letter_q);
  assign slot      = letter_slot(letter_q);
  assign cur_ent   = lower ? rd_ent[slot] : '0;

  for (genvar g = 0; g < ALPHABET; g++) begin : g_row
    assign rd_ent[g] = rd_row[g*EW +: EW];
    assign wr_row[g*EW +: EW] = (SLOT_W'(g) == slot) ? new_ent : rd_ent[g];
  end

  assign mem_we    = (state_q == ST_CLEAR) || dict_we;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : ins_node_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : wr_row;
  assign mem_raddr = cmd_i ? walk_node_q : ins_node_q;

  tsrr_row_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (RW),
    .AW    (NW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (mem_raddr),
    .rdata_o (rd_row)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == NW'(MAX_NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // dictionary insert
  always_comb begin
    nodes_used_d = nodes_used_q;
    ins_node_d   = ins_node_q;
    skip_d       = skip_q;
    error_d      = error_q;
    new_ent      = cur_ent;
    dict_we      = 1'b0;
    if ((state_q == ST_EXEC) && !cmd_q) begin
      if (!skip_q) begin
        priority if (!lower) begin
          skip_d  = 1'b1;
          error_d = 1'b1;
        end else if (cur_ent[NW-1:0] != '0) begin
          new_ent    = {cur_ent[NW] | word_end_q, cur_ent[NW-1:0]};
          dict_we    = word_end_q;
          ins_node_d = cur_ent[NW-1:0];
        end else if (nodes_used_q < (NW+1)'(MAX_NODES)) begin
          new_ent      = {word_end_q, nodes_used_q[NW-1:0]};
          dict_we      = 1'b1;
          nodes_used_d = nodes_used_q + 1'b1;
          ins_node_d   = nodes_used_q[NW-1:0];
        end else begin
          skip_d  = 1'b1;
          error_d = 1'b1;
        end
      end
      if (word_end_q) begin
        ins_node_d = '0;
        skip_d     = 1'b0;
      end
    end
  end

  // sentence walk
  always_comb begin
    walk_node_d = walk_node_q;
    mode_d      = mode_q;
    has         = 1'b1;
    if (walk_fire) begin
      if (letter_q == CH_SPACE) begin
        walk_node_d = '0;
        mode_d      = MODE_WALK;
      end else begin
        unique case (mode_q)
          MODE_MATCHED: begin
            has = 1'b0;
          end
          MODE_WALK: begin
            if (cur_ent[NW-1:0] == '0) begin
              mode_d = MODE_FAILED;
            end else begin
              walk_node_d = cur_ent[NW-1:0];
              if (cur_ent[NW]) begin
                mode_d = MODE_MATCHED;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (word_end_q) begin
        walk_node_d = '0;
        mode_d      = MODE_WALK;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (walk_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      nodes_used_q <= (NW+1)'(1);
      walk_node_q  <= '0;
      mode_q       <= MODE_WALK;
      ins_node_q   <= '0;
      skip_q       <= 1'b0;
      error_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      nodes_used_q <= nodes_used_d;
      walk_node_q  <= walk_node_d;
      mode_q       <= mode_d;
      ins_node_q   <= ins_node_d;
      skip_q       <= skip_d;
      error_q      <= error_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      letter_q   <= letter_i;
      word_end_q <= word_end_i;
    end
    if (walk_fire) begin
      out_char_q     <= has ? letter_q : 8'h00;
      has_char_q     <= has;
      sentence_end_q <= word_end_q;
      dict_error_q   <= error_q;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign has_char_o     = has_char_q;
  assign sentence_end_o = sentence_end_q;
  assign dict_error_o   = dict_error_q;

  `TSRR_ASSERT(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o, "accept during clear")
  `TSRR_ASSERT(a_nodes_bound, nodes_used_q <= (NW+1)'(MAX_NODES), "node count over store size")
  `TSRR_ASSERT(a_error_sticky, error_q |=> error_q, "dictionary error flag dropped")
  `TSRR_ASSERT(a_result_source, (out_valid_o && !$past(out_valid_o)) |-> $past(walk_fire), "result without sentence byte")
  `TSRR_ASSERT_ALWAYS(a_no_dict_write_idle, dict_we |-> (state_q == ST_EXEC), "row write outside exec")

endmodule

`default_nettype wire

// ===== sim/tsrr_rewrite_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie root replace checker
// Watches both channels of the trie rewriting block, keeps its own trie and
// walk state, predicts each rewritten sentence byte and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------

module tsrr_rewrite_checker
  import tsrr_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [7:0]  letter_i,
  input  logic        word_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic        has_char_i,
  input  logic        sentence_end_i,
  input  logic        dict_error_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output logic        store_full_o
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       sentence_end;
    logic       dict_error;
  } rewrite_t;

  logic [NODE_W-1:0] child_tbl [MAX_NODES*ALPHABET];
  logic              end_mark  [MAX_NODES];
  int unsigned       nodes_used;
  int unsigned       walk_node;
  mode_e             walk_mode;
  int unsigned       ins_node;
  logic              ins_skip;
  logic              dict_err;
  rewrite_t          rewrite_q[$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    results_o    = 0;
    store_full_o = 1'b0;
  end

  function automatic logic in_alphabet(input logic [7:0] c);
    return (c >= CH_A) && (int'(c) < int'(CH_A) + ALPHABET);
  endfunction

  function automatic void reset_trie();
    foreach (child_tbl[i]) child_tbl[i] = '0;
    foreach (end_mark[i]) end_mark[i] = 1'b0;
    nodes_used = 1;
    walk_node  = 0;
    walk_mode  = MODE_WALK;
    ins_node   = 0;
    ins_skip   = 1'b0;
    dict_err   = 1'b0;
    rewrite_q.delete();
  endfunction

  function automatic void trie_insert_byte(input logic [7:0] c, input logic last);
    int unsigned       slot;
    logic [NODE_W-1:0] child;
    if (!ins_skip) begin
      if (!in_alphabet(c) || ins_node >= MAX_NODES) begin
        ins_skip = 1'b1;
        dict_err = 1'b1;
      end else begin
        slot  = ins_node * ALPHABET + (int'(c) - int'(CH_A));
        child = child_tbl[slot];
        if (child == '0) begin
          if (nodes_used < MAX_NODES) begin
            child = NODE_W'(nodes_used);
            nodes_used++;
            child_tbl[slot] = child;
          end else begin
            ins_skip = 1'b1;
            dict_err = 1'b1;
          end
        end
        if (!ins_skip) ins_node = child;
      end
    end
    if (last) begin
      if (!ins_skip && ins_node < MAX_NODES) end_mark[ins_node] = 1'b1;
      ins_node = 0;
      ins_skip = 1'b0;
    end
  endfunction

  function automatic rewrite_t rewrite_byte(input logic [7:0] c, input logic last);
    rewrite_t          r;
    logic [NODE_W-1:0] nxt;
    r.has_char = 1'b1;
    if (c == CH_SPACE) begin
      walk_node = 0;
      walk_mode = MODE_WALK;
    end else if (walk_mode == MODE_MATCHED) begin
      r.has_char = 1'b0;
    end else if (walk_mode == MODE_WALK) begin
      nxt = '0;
      if (in_alphabet(c) && walk_node < MAX_NODES)
        nxt = child_tbl[walk_node * ALPHABET + (int'(c) - int'(CH_A))];
      if (nxt == '0) begin
        walk_mode = MODE_FAILED;
      end else begin
        walk_node = nxt;
        if (end_mark[nxt]) walk_mode = MODE_MATCHED;
      end
    end
    r.out_char     = r.has_char ? c : 8'h00;
    r.sentence_end = last;
    r.dict_error   = dict_err;
    if (last) begin
      walk_node = 0;
      walk_mode = MODE_WALK;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rewrite_t got;
    rewrite_t want;
    if (!rst_ni) begin
      reset_trie();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{out_char: out_char_i, has_char: has_char_i,
                sentence_end: sentence_end_i, dict_error: dict_error_i};
        results_o++;
        if (rewrite_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("[%0t] unexpected result: char=%02h has=%0b end=%0b err=%0b",
                     $realtime, got.out_char, got.has_char, got.sentence_end,
                     got.dict_error);
        end else begin
          want = rewrite_q.pop_front();
          if (got != want) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display({"[%0t] mismatch: expected char=%02h has=%0b end=%0b err=%0b,",
                        " got char=%02h has=%0b end=%0b err=%0b"},
                       $realtime, want.out_char, want.has_char, want.sentence_end,
                       want.dict_error, got.out_char, got.has_char, got.sentence_end,
                       got.dict_error);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i) rewrite_q.push_back(rewrite_byte(letter_i, word_end_i));
        else trie_insert_byte(letter_i, word_end_i);
      end
    end
    pending_o    = rewrite_q.size();
    store_full_o = (nodes_used == MAX_NODES);
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie root replace testbench
// Builds dictionaries and rewrites sentences through the block: a short
// directed set, random dictionary words and sentences with noise, then a
// fill of the whole node store. A checker beside the block predicts and
// compares every result; this top drives traffic and gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
  import tsrr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        cmd        = 1'b0;
  logic [7:0]  letter     = 8'h00;
  logic        word_end   = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [7:0]  out_char;
  logic        has_char;
  logic        sentence_end;
  logic        dict_error;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  logic        store_full;

  int unsigned sent       = 0;
  int unsigned dict_sent  = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_kind = 0;

  always #6 clk = ~clk;

  trie_shortest_root_replace dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .letter_i       (letter),
    .word_end_i     (word_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_char_o     (out_char),
    .has_char_o     (has_char),
    .sentence_end_o (sentence_end),
    .dict_error_o   (dict_error)
  );

  tsrr_rewrite_checker rewrite_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .letter_i       (letter),
    .word_end_i     (word_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_char_i     (out_char),
    .has_char_i     (has_char),
    .sentence_end_i (sentence_end),
    .dict_error_i   (dict_error),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .results_o      (results),
    .store_full_o   (store_full)
  );

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_kind)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ((stall_left % 16) < 4);
    endcase
  end

  task automatic send_byte(input logic c, input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    letter   <= b;
    word_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
    if (!c) dict_sent++;
  endtask

  task automatic send_text(input logic c, input string s, input logic last);
    for (int i = 0; i < s.len(); i++)
      send_byte(c, s[i], last && (i == s.len() - 1));
  endtask

  // hold the input idle until every sentence byte's result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] rand_letter(input logic full);
    return CH_A + 8'(full ? $urandom_range(0, 25) : $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= CH_A && int'(b) < int'(CH_A) + ALPHABET);
    return b;
  endfunction

  task automatic send_dict_word(input int unsigned len, input logic full, input logic bad);
    int unsigned bad_pos;
    bad_pos = $urandom_range(0, len - 1);
    for (int unsigned i = 0; i < len; i++)
      send_byte(1'b0, (bad && i == bad_pos) ? bad_byte() : rand_letter(full), i == len - 1);
  endtask

  task automatic send_sentence(input int unsigned words, input logic full,
                               input logic terminate);
    int unsigned len;
    logic [7:0]  b;
    for (int unsigned w = 0; w < words; w++) begin
      len = $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) begin
        b = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255)) : rand_letter(full);
        send_byte(1'b1, b, terminate && w == words - 1 && i == len - 1);
      end
      if (w != words - 1) send_byte(1'b1, CH_SPACE, 1'b0);
    end
  endtask

  initial begin
    int unsigned phase_start;
    logic        noisy;
    int unsigned pick;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text(1'b0, "ab", 1'b1);
    send_text(1'b0, "z", 1'b1);
    send_text(1'b1, "abcd ax", 1'b0);
    send_byte(1'b1, 8'hFF, 1'b0);
    send_byte(1'b1, CH_SPACE, 1'b0);
    send_byte(1'b1, 8'h7B, 1'b0);
    send_byte(1'b1, 8'h00, 1'b0);
    send_byte(1'b1, CH_SPACE, 1'b0);
    send_text(1'b1, "zz", 1'b1);
    send_text(1'b1, "b", 1'b0);
    send_byte(1'b1, 8'h60, 1'b1);
    send_text(1'b1, "a", 1'b0);
    send_text(1'b0, "y", 1'b1);
    send_text(1'b1, "b", 1'b1);
    drain();

    phase_start = sent;
    while (sent - phase_start < RANDOM_ITEMS) begin
      noisy = (sent - phase_start) > (RANDOM_ITEMS * 3) / 4;
      pick  = $urandom_range(0, 99);
      if (pick < 35)
        send_dict_word($urandom_range(1, 5), $urandom_range(0, 3) == 0,
                       noisy && $urandom_range(0, 9) == 0);
      else if (pick < 88)
        send_sentence($urandom_range(1, 4), $urandom_range(0, 3) == 0,
                      !(noisy && $urandom_range(0, 4) == 0));
      else
        send_byte(noisy ? 1'($urandom_range(0, 1)) : 1'b1, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) == 0);
    end
    drain();

    // fill the node store, then push words that need nodes it no longer has
    while (!store_full) send_dict_word($urandom_range(10, 16), 1'b1, 1'b0);
    repeat (4) send_dict_word($urandom_range(3, 8), 1'b1, 1'b0);
    send_text(1'b0, "q", 1'b0);
    send_byte(1'b0, 8'h7B, 1'b0);
    send_text(1'b0, "rs", 1'b1);
    phase_start = sent;
    while (sent - phase_start < 200)
      send_sentence($urandom_range(1, 4), $urandom_range(0, 1), 1'b1);
    drain();
    repeat (20) @(negedge clk);

    $display("Run covered %0d input transactions (%0d dictionary bytes), %0d results checked.",
             sent, dict_sent, results);
    $display("Node store filled: %s; walks matched, suppressed, failed and passed through.",
             store_full ? "yes" : "no");
    if (mismatches == 0 && pending == 0) begin
      $display("[trie_shortest_root_replace] OK");
    end else begin
      $display("[trie_shortest_root_replace] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[trie_shortest_root_replace] ERROR");
    $finish;
  end

endmodule
